@@ hw/rtl/bpfa_pkg.sv @@
package bpfa_pkg;

   // Page numbers, run lengths and limits all fit in 17 bits
   localparam int PAGE_W = 17;
   // Bitmap memory word: eight pages per word
   localparam int WORD_W = 8;
   localparam int BIT_W  = 3;
   localparam int WIDX_W = PAGE_W - BIT_W;

   typedef enum logic [2:0] {
      KIND_LOCK      = 3'd0,
      KIND_FREE      = 3'd1,
      KIND_RESERVE   = 3'd2,
      KIND_UNRESERVE = 3'd3,
      KIND_REQUEST   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_NOMEM = 2'd2
   } status_type;

   typedef enum logic {
      CSR_PAGE_LIMIT  = 1'b0,
      CSR_TOTAL_PAGES = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_RUN   = 4'b0100,
      S_SCAN  = 4'b1000
   } state_type;

endpackage

@@ hw/rtl/bpfa_ram.sv @@
module bpfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/bitmap_page_frame_allocator.sv @@
// Bitmap page frame allocator: one used bit per page, kept in a memory of
// 8-page words, plus a search hint and free, used and reserved counters.
// Request channel: req_kind, req_first_page, req_page_count are taken at a
// rising edge with start high and busy low. Lock, free, reserve and
// unreserve walk the run one bitmap word per cycle (read of the next word
// overlaps the write-back of the current one); request scans from the hint
// one word per cycle until a clear bit or the page limit.
// An empty run, an unknown kind or a request with the hint at the limit is
// answered from idle without touching the bitmap.
// The result appears for one cycle with rsp_valid high; busy is already low
// in that cycle, so the next request may be taken there. The receiver cannot
// stall, so nothing is held back for it.
// Configuration: csr_valid/csr_ready, csr_index (0 page limit, 1 total pages),
// csr_wdata; csr_ready stays high; users write only while idle (not enforced).
// Reset: synchronous, active high. After reset a clearing pass writes zero
// to every bitmap word, with busy high throughout.
module bitmap_page_frame_allocator #(
   parameter int MAX_PAGES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_first_page,
   input  logic [16:0] req_page_count,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_granted_page,
   output logic [16:0] rsp_pages_done,
   output logic [31:0] rsp_free_count,
   output logic [31:0] rsp_used_count,
   output logic [31:0] rsp_reserved_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);

   localparam int DEPTH  = (MAX_PAGES + bpfa_pkg::WORD_W - 1) / bpfa_pkg::WORD_W;
   localparam int ADDR_W = $clog2(DEPTH);

   bpfa_pkg::state_type               state_ff, state_in;
   logic [bpfa_pkg::PAGE_W-1:0]       page_limit_ff, page_limit_in;
   logic [31:0]                       free_ff, free_in;
   logic [31:0]                       used_ff, used_in;
   logic [31:0]                       resv_ff, resv_in;
   logic [bpfa_pkg::PAGE_W-1:0]       hint_ff, hint_in;
   logic [2:0]                        kind_ff, kind_in;
   logic [bpfa_pkg::PAGE_W-1:0]       first_ff, first_in;
   logic [bpfa_pkg::PAGE_W-1:0]       end_ff, end_in;
   logic [bpfa_pkg::WIDX_W-1:0]       word_ff, word_in;
   logic [bpfa_pkg::WIDX_W-1:0]       last_ff, last_in;
   logic [ADDR_W-1:0]                 clr_ff, clr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   bpfa_pkg::status_type              status_ff, status_in;
   logic [15:0]                       granted_ff, granted_in;
   logic [bpfa_pkg::PAGE_W-1:0]       done_ff, done_in;

   logic                              ram_wr_en;
   logic [ADDR_W-1:0]                 ram_wr_addr;
   logic [bpfa_pkg::WORD_W-1:0]       ram_wr_data;
   logic                              ram_rd_en;
   logic [ADDR_W-1:0]                 ram_rd_addr;
   logic [bpfa_pkg::WORD_W-1:0]       ram_rd_data;

   logic [bpfa_pkg::PAGE_W-1:0]       lim;
   logic [bpfa_pkg::PAGE_W-1:0]       first_req;
   logic [bpfa_pkg::PAGE_W:0]         run_sum;
   logic [bpfa_pkg::PAGE_W-1:0]       run_done;
   logic [bpfa_pkg::PAGE_W-1:0]       run_end;
   logic [bpfa_pkg::PAGE_W-1:0]       run_last;
   logic [bpfa_pkg::WORD_W-1:0]       run_mask;
   logic [bpfa_pkg::WORD_W-1:0]       scan_cand;
   logic [bpfa_pkg::BIT_W-1:0]        scan_bit;
   logic [bpfa_pkg::PAGE_W-1:0]       scan_page;
   logic [bpfa_pkg::PAGE_W:0]         scan_next;
   logic                              set_run;

   bpfa_ram #(
      .WIDTH(bpfa_pkg::WORD_W),
      .DEPTH(DEPTH)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Effective limit: page limit capped at the bitmap size
   assign lim = (32'(page_limit_ff) < 32'(MAX_PAGES)) ? page_limit_ff
                                                       : bpfa_pkg::PAGE_W'(MAX_PAGES);

   // Run length that stays below the limit
   assign first_req = {1'b0, req_first_page};
   assign run_sum   = {1'b0, first_req} + {1'b0, req_page_count};
   always_comb begin
      if (run_sum <= {1'b0, lim}) begin
         run_done = req_page_count;
      end else if (first_req < lim) begin
         run_done = lim - first_req;
      end else begin
         run_done = '0;
      end
   end
   assign run_end  = first_req + run_done;
   assign run_last = run_end - 1'b1;

   // Pages of the current word that lie inside the run
   always_comb begin
      for (int j = 0; j < bpfa_pkg::WORD_W; j++) begin
         run_mask[j] = ({word_ff, bpfa_pkg::BIT_W'(j)} >= first_ff) &&
                       ({word_ff, bpfa_pkg::BIT_W'(j)} < end_ff);
      end
   end
   assign set_run = (kind_ff == bpfa_pkg::KIND_LOCK) || (kind_ff == bpfa_pkg::KIND_RESERVE);

   // Clear pages of the scanned word at or above the hint and below the limit
   always_comb begin
      scan_bit = '0;
      for (int j = 0; j < bpfa_pkg::WORD_W; j++) begin
         scan_cand[j] = !ram_rd_data[j] &&
            ({hint_ff[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_W], bpfa_pkg::BIT_W'(j)} >= hint_ff) &&
            ({hint_ff[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_W], bpfa_pkg::BIT_W'(j)} < lim);
      end
      for (int j = bpfa_pkg::WORD_W - 1; j >= 0; j--) begin
         if (scan_cand[j]) begin
            scan_bit = bpfa_pkg::BIT_W'(j);
         end
      end
   end
   assign scan_page = {hint_ff[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_W], scan_bit};
   assign scan_next = {1'b0, hint_ff[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_W], {bpfa_pkg::BIT_W{1'b0}}}
                      + (bpfa_pkg::PAGE_W + 1)'(bpfa_pkg::WORD_W);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      page_limit_in = page_limit_ff;
      free_in       = free_ff;
      used_in       = used_ff;
      resv_in       = resv_ff;
      hint_in       = hint_ff;
      kind_in       = kind_ff;
      first_in      = first_ff;
      end_in        = end_ff;
      word_in       = word_ff;
      last_in       = last_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      status_in     = status_ff;
      granted_in    = granted_ff;
      done_in       = done_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = ADDR_W'(word_ff);
      ram_wr_data   = set_run ? (ram_rd_data | run_mask) : (ram_rd_data & ~run_mask);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ADDR_W'(word_ff);

      unique case (state_ff)
         bpfa_pkg::S_CLEAR: begin
            // Sweep zeros through the bitmap
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = bpfa_pkg::S_IDLE;
            end
         end
         bpfa_pkg::S_IDLE: begin
            if (start) begin
               kind_in    = req_kind;
               status_in  = bpfa_pkg::ST_OK;
               granted_in = '0;
               done_in    = '0;
               unique case (req_kind)
                  bpfa_pkg::KIND_LOCK, bpfa_pkg::KIND_FREE,
                  bpfa_pkg::KIND_RESERVE, bpfa_pkg::KIND_UNRESERVE: begin
                     done_in   = run_done;
                     status_in = (run_done != req_page_count) ? bpfa_pkg::ST_RANGE
                                                              : bpfa_pkg::ST_OK;
                     unique case (req_kind)
                        bpfa_pkg::KIND_LOCK: begin
                           free_in = free_ff - 32'(run_done);
                           used_in = used_ff + 32'(run_done);
                        end
                        bpfa_pkg::KIND_FREE: begin
                           free_in = free_ff + 32'(run_done);
                           used_in = used_ff - 32'(run_done);
                        end
                        bpfa_pkg::KIND_RESERVE: begin
                           free_in = free_ff - 32'(run_done);
                           resv_in = resv_ff + 32'(run_done);
                        end
                        default: begin
                           free_in = free_ff + 32'(run_done);
                           resv_in = resv_ff - 32'(run_done);
                        end
                     endcase
                     // Lower the hint to the first page cleared
                     if ((req_kind == bpfa_pkg::KIND_FREE ||
                          req_kind == bpfa_pkg::KIND_UNRESERVE) &&
                         run_done != '0 && first_req < hint_ff) begin
                        hint_in = first_req;
                     end
                     if (run_done == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        first_in    = first_req;
                        end_in      = run_end;
                        word_in     = first_req[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_W];
                        last_in     = run_last[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_W];
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(first_req[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_W]);
                        state_in    = bpfa_pkg::S_RUN;
                     end
                  end
                  bpfa_pkg::KIND_REQUEST: begin
                     if (hint_ff >= lim) begin
                        status_in    = bpfa_pkg::ST_NOMEM;
                        rsp_valid_in = 1'b1;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(hint_ff[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_W]);
                        state_in    = bpfa_pkg::S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         bpfa_pkg::S_RUN: begin
            // Write back this word, read the next one unless this is the last
            ram_wr_en = 1'b1;
            if (word_ff == last_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = bpfa_pkg::S_IDLE;
            end else begin
               word_in     = word_ff + 1'b1;
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(word_ff + 1'b1);
            end
         end
         bpfa_pkg::S_SCAN: begin
            if (|scan_cand) begin
               // Lock the first clear page and leave the hint on it
               ram_wr_en   = 1'b1;
               ram_wr_addr = ADDR_W'(hint_ff[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_W]);
               ram_wr_data = ram_rd_data | (bpfa_pkg::WORD_W'(1) << scan_bit);
               hint_in     = scan_page;
               free_in     = free_ff - 32'd1;
               used_in     = used_ff + 32'd1;
               granted_in  = scan_page[15:0];
               done_in     = bpfa_pkg::PAGE_W'(1);
               rsp_valid_in = 1'b1;
               state_in    = bpfa_pkg::S_IDLE;
            end else if (scan_next >= {1'b0, lim}) begin
               // No clear page below the limit
               hint_in      = lim;
               status_in    = bpfa_pkg::ST_NOMEM;
               rsp_valid_in = 1'b1;
               state_in     = bpfa_pkg::S_IDLE;
            end else begin
               // Advance to the next word
               hint_in     = scan_next[bpfa_pkg::PAGE_W-1:0];
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(scan_next[bpfa_pkg::PAGE_W-1:bpfa_pkg::BIT_W]);
            end
         end
         default: begin
            state_in = bpfa_pkg::S_IDLE;
         end
      endcase

      // Configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            bpfa_pkg::CSR_PAGE_LIMIT: begin
               page_limit_in = csr_wdata;
            end
            bpfa_pkg::CSR_TOTAL_PAGES: begin
               free_in = 32'(csr_wdata);
               used_in = '0;
               resv_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bpfa_pkg::S_CLEAR;
         page_limit_ff <= 17'h10000;
         free_ff       <= '0;
         used_ff       <= '0;
         resv_ff       <= '0;
         hint_ff       <= '0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         page_limit_ff <= page_limit_in;
         free_ff       <= free_in;
         used_ff       <= used_in;
         resv_ff       <= resv_in;
         hint_ff       <= hint_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Request payload and result fields
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      first_ff   <= first_in;
      end_ff     <= end_in;
      word_ff    <= word_in;
      last_ff    <= last_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      done_ff    <= done_in;
   end

   assign busy               = (state_ff != bpfa_pkg::S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_page   = granted_ff;
   assign rsp_pages_done     = done_ff;
   assign rsp_free_count     = free_ff;
   assign rsp_used_count     = used_ff;
   assign rsp_reserved_count = resv_ff;

endmodule

@@ tb/page_alloc_checker.sv @@
module page_alloc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_first_page,
   input  logic [16:0] req_page_count,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_granted_page,
   input  logic [16:0] rsp_pages_done,
   input  logic [31:0] rsp_free_count,
   input  logic [31:0] rsp_used_count,
   input  logic [31:0] rsp_reserved_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata,
   output int          outstanding,
   output int          mismatches,
   output int          compared
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAP_PAGES = 65536;
   // keep the log short when the block is badly broken
   localparam int LOG_CAP = 100;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted;
      logic [16:0] done;
      logic [31:0] free_cnt;
      logic [31:0] used_cnt;
      logic [31:0] rsvd_cnt;
   } page_outcome_type;

   bit [MAP_PAGES-1:0] used_map;
   logic [16:0]        scan_hint;
   logic [31:0]        free_ctr;
   logic [31:0]        used_ctr;
   logic [31:0]        rsvd_ctr;
   logic [16:0]        limit_reg;
   page_outcome_type   awaited_outcomes[$];

   function automatic int unsigned tracked_pages();
      return (limit_reg < MAP_PAGES) ? limit_reg : MAP_PAGES;
   endfunction

   // Apply one page of a run; false once the page lies at or past the limit
   function automatic bit touch_page(logic [2:0] kind, int unsigned page);
      if (page >= tracked_pages())
         return 1'b0;
      case (kind)
         bpfa_pkg::KIND_LOCK: begin
            used_map[page] = 1'b1;
            free_ctr--;
            used_ctr++;
         end
         bpfa_pkg::KIND_FREE: begin
            used_map[page] = 1'b0;
            free_ctr++;
            used_ctr--;
            if (page < scan_hint)
               scan_hint = 17'(page);
         end
         bpfa_pkg::KIND_RESERVE: begin
            used_map[page] = 1'b1;
            free_ctr--;
            rsvd_ctr++;
         end
         default: begin
            used_map[page] = 1'b0;
            free_ctr++;
            rsvd_ctr--;
            if (page < scan_hint)
               scan_hint = 17'(page);
         end
      endcase
      return 1'b1;
   endfunction

   // Advance the allocator state by one request and return its outcome
   function automatic page_outcome_type predict_page_op(logic [2:0] kind, logic [15:0] first,
                                                        logic [16:0] count);
      page_outcome_type res;
      int unsigned      lim;
      int unsigned      n;
      bit               stopped;
      res = '0;
      lim = tracked_pages();
      stopped = 1'b0;
      if (kind <= bpfa_pkg::KIND_UNRESERVE) begin
         for (n = 0; n < count && !stopped; n++) begin
            if (touch_page(kind, 32'(first) + n))
               res.done = res.done + 17'd1;
            else begin
               stopped = 1'b1;
               res.status = bpfa_pkg::ST_RANGE;
            end
         end
      end else if (kind == bpfa_pkg::KIND_REQUEST) begin
         // walk the hint up to the first clear page, leave it there
         while (scan_hint < lim && used_map[scan_hint])
            scan_hint++;
         if (scan_hint < lim) begin
            void'(touch_page(bpfa_pkg::KIND_LOCK, 32'(scan_hint)));
            res.granted = scan_hint[15:0];
            res.done = 17'd1;
         end else
            res.status = bpfa_pkg::ST_NOMEM;
      end
      res.free_cnt = free_ctr;
      res.used_cnt = used_ctr;
      res.rsvd_cnt = rsvd_ctr;
      return res;
   endfunction

   task automatic report_error(input string msg);
      if (mismatches < LOG_CAP)
         $display("%0t ERROR response %0d: %s", $time, compared, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin : watch
      page_outcome_type want;
      if (reset) begin
         used_map = '0;
         scan_hint = '0;
         limit_reg = 17'd65536;
         free_ctr = '0;
         used_ctr = '0;
         rsvd_ctr = '0;
         awaited_outcomes.delete();
         mismatches = 0;
         compared = 0;
      end else begin
         // compare each response with the oldest prediction
         if (rsp_valid) begin
            if (awaited_outcomes.size() == 0)
               report_error("response with no request outstanding");
            else begin
               want = awaited_outcomes.pop_front();
               check_field("status", 32'(rsp_status), 32'(want.status));
               check_field("granted_page", 32'(rsp_granted_page), 32'(want.granted));
               check_field("pages_done", 32'(rsp_pages_done), 32'(want.done));
               check_field("free_count", rsp_free_count, want.free_cnt);
               check_field("used_count", rsp_used_count, want.used_cnt);
               check_field("reserved_count", rsp_reserved_count, want.rsvd_cnt);
            end
            compared++;
         end
         // follow register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == bpfa_pkg::CSR_PAGE_LIMIT)
               limit_reg = csr_wdata;
            else begin
               free_ctr = 32'(csr_wdata);
               used_ctr = '0;
               rsvd_ctr = '0;
            end
         end
         // predict each accepted request
         if (start && !busy)
            awaited_outcomes.push_back(predict_page_op(req_kind, req_first_page,
                                                       req_page_count));
      end
      outstanding <= awaited_outcomes.size();
   end

endmodule

@@ tb/bitmap_page_frame_allocator_tb.sv @@
module bitmap_page_frame_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HANG_LIMIT      = 40000;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int TAIL_CYCLES     = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_kind = '0;
   logic [15:0] req_first_page = '0;
   logic [16:0] req_page_count = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_granted_page;
   logic [16:0] rsp_pages_done;
   logic [31:0] rsp_free_count;
   logic [31:0] rsp_used_count;
   logic [31:0] rsp_reserved_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [16:0] csr_wdata = '0;

   int          outstanding;
   int          mismatches;
   int          compared;
   int          hang_cycles = 0;
   int unsigned idle_pct = 0;
   int unsigned cur_limit = 65536;
   int unsigned requests_sent = 0;
   int unsigned reg_writes = 0;

   bitmap_page_frame_allocator dut (.*);

   page_alloc_checker alloc_check (.*);

   always #2 clock = ~clock;

   // Abort when no handshake of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         hang_cycles <= 0;
      else
         hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HANG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", hang_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Hold off requests until every response is back and the block is idle
   task automatic wait_all_done();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy)
         @(posedge clock);
   endtask

   task automatic write_reg(input bpfa_pkg::csr_index_type idx, input logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == bpfa_pkg::CSR_PAGE_LIMIT)
         cur_limit = value;
      reg_writes++;
      @(posedge clock);
   endtask

   // Present one request, wait for it to be taken, then maybe idle
   task automatic issue(input logic [2:0] kind, input logic [15:0] first,
                        input logic [16:0] count);
      start <= 1'b1;
      req_kind <= kind;
      req_first_page <= first;
      req_page_count <= count;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      requests_sent++;
      if ($urandom_range(0, 99) < 3)
         wait_all_done();
      else if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6))
            @(posedge clock);
      end
   endtask

   initial begin
      logic [2:0]  kind;
      logic [15:0] first;
      logic [16:0] count;
      int unsigned span;
      int unsigned pick;
      logic [16:0] lim_plan [6];
      logic [16:0] total_plan [6];

      repeat (7)
         @(posedge clock);
      reset <= 1'b0;
      idle_pct = 13;
      // the block clears its bitmap after reset
      wait_all_done();

      // Directed: full memory, run edges, every operation
      write_reg(bpfa_pkg::CSR_TOTAL_PAGES, 17'd65536);
      issue(bpfa_pkg::KIND_LOCK, 16'd0, 17'd0);
      issue(bpfa_pkg::KIND_LOCK, 16'd10, 17'd5);
      issue(bpfa_pkg::KIND_LOCK, 16'hFFFF, 17'd2);
      issue(bpfa_pkg::KIND_LOCK, 16'd12, 17'd1);
      issue(bpfa_pkg::KIND_FREE, 16'hFFFF, 17'd1);
      issue(bpfa_pkg::KIND_REQUEST, 16'($urandom), 17'($urandom));
      issue(bpfa_pkg::KIND_REQUEST, 16'($urandom), 17'($urandom));
      issue(bpfa_pkg::KIND_RESERVE, 16'd20, 17'd3);
      issue(bpfa_pkg::KIND_UNRESERVE, 16'd21, 17'd1);
      issue(bpfa_pkg::KIND_UNRESERVE, 16'd0, 17'd1);
      issue(bpfa_pkg::KIND_REQUEST, 16'($urandom), 17'($urandom));
      // unknown kinds must leave everything alone
      for (int k = bpfa_pkg::KIND_REQUEST + 1; k < 8; k++)
         issue(3'(k), 16'($urandom), 17'($urandom_range(0, 65536)));
      // whole map freed, then whole map taken, then out of memory twice
      issue(bpfa_pkg::KIND_FREE, 16'd0, 17'd65536);
      issue(bpfa_pkg::KIND_LOCK, 16'd0, 17'd65536);
      issue(bpfa_pkg::KIND_REQUEST, 16'($urandom), 17'($urandom));
      issue(bpfa_pkg::KIND_REQUEST, 16'($urandom), 17'($urandom));

      // zero limit: every page is out of range, hint stays above it
      wait_all_done();
      write_reg(bpfa_pkg::CSR_PAGE_LIMIT, 17'd0);
      issue(bpfa_pkg::KIND_LOCK, 16'd0, 17'd1);
      issue(bpfa_pkg::KIND_REQUEST, 16'($urandom), 17'($urandom));

      // small limit: free drops the hint, run crosses the limit
      wait_all_done();
      write_reg(bpfa_pkg::CSR_PAGE_LIMIT, 17'd70);
      issue(bpfa_pkg::KIND_FREE, 16'd5, 17'd3);
      issue(bpfa_pkg::KIND_REQUEST, 16'($urandom), 17'($urandom));
      issue(bpfa_pkg::KIND_LOCK, 16'd69, 17'd4);
      issue(bpfa_pkg::KIND_REQUEST, 16'($urandom), 17'($urandom));

      // Random phases under several register settings
      lim_plan = '{17'd64, 17'd1000, 17'd65536, 17'd8, 17'd65536,
                   17'($urandom_range(1, 4096))};
      total_plan = '{17'd64, 17'($urandom_range(0, 65536)), 17'd65536, 17'd5, 17'd0,
                     17'($urandom_range(0, 65536))};
      for (int phase = 0; phase < 6; phase++) begin
         idle_pct = (phase < 2) ? 13 : (phase < 4) ? 68 : 0;
         wait_all_done();
         write_reg(bpfa_pkg::CSR_PAGE_LIMIT, lim_plan[phase]);
         write_reg(bpfa_pkg::CSR_TOTAL_PAGES, total_plan[phase]);
         // start the wide phase from an empty map so scans stay short
         if (phase == 2)
            issue(bpfa_pkg::KIND_FREE, 16'd0, 17'd65536);
         repeat (ITEMS_PER_PHASE) begin
            span = (cur_limit > 65536) ? 65536 : cur_limit;
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               // noise: any kind, any page, long runs only where the limit is low
               kind = 3'($urandom_range(0, 7));
               first = 16'($urandom);
               count = (span <= 4096) ? 17'($urandom_range(0, 65536))
                                      : 17'($urandom_range(0, 64));
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 30)
                  kind = bpfa_pkg::KIND_REQUEST;
               else if (pick < 50)
                  kind = bpfa_pkg::KIND_LOCK;
               else if (pick < 70)
                  kind = bpfa_pkg::KIND_FREE;
               else if (pick < 85)
                  kind = bpfa_pkg::KIND_RESERVE;
               else
                  kind = bpfa_pkg::KIND_UNRESERVE;
               first = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, span - 1));
               pick = $urandom_range(0, 9);
               count = (pick == 0) ? 17'd0 :
                       (pick == 1) ? 17'($urandom_range(1, 64)) : 17'($urandom_range(1, 8));
            end
            issue(kind, first, count);
         end
      end

      wait_all_done();
      repeat (TAIL_CYCLES)
         @(posedge clock);
      $display("Covered %0d requests across %0d register writes (limits 0 to 65536),",
               requests_sent, reg_writes);
      $display("with %0d responses compared field by field.", compared);
      if (mismatches == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
